### hdl/move_to_front_list_engine_macros.svh
// ----------------------------------------------------------------------------
// move_to_front_list_engine_macros.svh
// Assertion macros shared by the list engine RTL. Define ASSERT_OFF to drop
// them. Each macro expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LIST_ENGINE_MACROS_SVH
`define MOVE_TO_FRONT_LIST_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Property holds at every edge outside reset.
`define MTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define MTF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define MTF_ASSERT(lbl, prop, msg)
`define MTF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types, codes and constants of the move-to-front list engine.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int unsigned MTF_DEPTH = 16;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_VALUE = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_MOVE_FRONT = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic    load;         // capture a new transaction
    logic    push_front;   // write value ahead of head
    logic    push_back;    // write value after the tail
    logic    read_front;   // issue a read of the head entry
    logic    take_front;   // pop the head, keep its data
    logic    scan_start;   // clear scan pointer
    logic    scan;         // one scan step
    logic    found;        // record the match index
    logic    shift_start;  // load shift pointer from match index
    logic    shift;        // one shift step
    logic    tail_remove;  // drop the head slot after a shift
    logic    tail_front;   // write value into the head slot
    logic    set_status;
    status_e status;
    logic    emit;         // load output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            hit;
    logic            miss;
    logic            shift_done;
  } sts_t;

endpackage

### hdl/mtf_ram.sv
// ----------------------------------------------------------------------------
// mtf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/mtf_dpath.sv
// ----------------------------------------------------------------------------
// mtf_dpath
// List storage as a circular buffer in RAM, head/length, scan and shift
// pointers, result and output registers.
// ----------------------------------------------------------------------------
`include "move_to_front_list_engine_macros.svh"

module mtf_dpath import mtf_pkg::*; #(
  parameter int unsigned DEPTH = MTF_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [OP_W-1:0]            operation_i,
  input  logic signed [VAL_W-1:0]    value_i,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic signed [VAL_W-1:0]    removed_value_o,
  output logic [POS_W-1:0]           position_o,
  output logic [COUNT_W-1:0]         entry_count_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] LEN_MAX   = CNT_W'(DEPTH);

  // physical slot of a logical offset from head
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] head_q;
  logic [CNT_W-1:0] len_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] pidx_q;
  logic             pend_q;

  logic [OP_W-1:0]  op_q;
  logic [VAL_W-1:0] value_q;
  logic [CNT_W-1:0] pos_q;
  logic [VAL_W-1:0] removed_q;
  status_e          stat_q;

  logic [IDX_W-1:0] head_dec;
  logic [IDX_W-1:0] head_inc;
  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] pidx_p1;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic             hit;
  logic             miss;

  logic [CNT_W+POS_W-1:0]   pos_wide;
  logic [CNT_W+COUNT_W-1:0] cnt_wide;

  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign head_inc = wrap_add(head_q, IDX_W'(1));
  assign idx_m1   = idx_q - 1'b1;
  assign pidx_p1  = pidx_q + 1'b1;

  assign hit  = pend_q && (ram_rdata == value_q);
  assign miss = pend_q && (ram_rdata != value_q) && (pidx_p1 == len_q);

  assign sts_o.op         = op_q;
  assign sts_o.full       = (len_q == LEN_MAX);
  assign sts_o.empty      = (len_q == '0);
  assign sts_o.hit        = hit;
  assign sts_o.miss       = miss;
  assign sts_o.shift_done = (idx_q == '0) && !pend_q;

  always_comb begin
    ram_raddr = wrap_add(head_q, idx_q[IDX_W-1:0]);
    priority if (cmd_i.read_front) begin
      ram_raddr = head_q;
    end else if (cmd_i.shift) begin
      ram_raddr = wrap_add(head_q, idx_m1[IDX_W-1:0]);
    end else begin
      ram_raddr = wrap_add(head_q, idx_q[IDX_W-1:0]);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = value_q;
    priority if (cmd_i.push_front) begin
      ram_we    = 1'b1;
      ram_waddr = head_dec;
    end else if (cmd_i.push_back) begin
      ram_we    = 1'b1;
      ram_waddr = wrap_add(head_q, len_q[IDX_W-1:0]);
    end else if (cmd_i.shift && pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wrap_add(head_q, pidx_q[IDX_W-1:0]);
      ram_wdata = ram_rdata;
    end else if (cmd_i.tail_front) begin
      ram_we    = 1'b1;
      ram_waddr = head_q;
    end else begin
      ram_we    = 1'b0;
    end
  end

  mtf_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH),
    .ADDR_W(IDX_W)
  ) u_list_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // list bookkeeping and walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      len_q  <= '0;
      idx_q  <= '0;
      pidx_q <= '0;
      pend_q <= 1'b0;
    end else begin
      priority if (cmd_i.load) begin
        pend_q <= 1'b0;
      end else if (cmd_i.push_front) begin
        head_q <= head_dec;
        len_q  <= len_q + 1'b1;
      end else if (cmd_i.push_back) begin
        len_q  <= len_q + 1'b1;
      end else if (cmd_i.take_front || cmd_i.tail_remove) begin
        head_q <= head_inc;
        len_q  <= len_q - 1'b1;
      end else if (cmd_i.scan_start) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.shift_start) begin
        idx_q  <= pidx_q;
        pend_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (idx_q < len_q) begin
          idx_q  <= idx_q + 1'b1;
          pidx_q <= idx_q;
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end else if (cmd_i.shift) begin
        if (idx_q != '0) begin
          idx_q  <= idx_m1;
          pidx_q <= idx_q;
          pend_q <= 1'b1;
        end else begin
          pend_q <= 1'b0;
        end
      end else begin
        pend_q <= pend_q;
      end
    end
  end

  assign pos_wide = {{POS_W{1'b0}}, pos_q};
  assign cnt_wide = {{COUNT_W{1'b0}}, len_q};

  // transaction operands, results, output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      value_q   <= value_i;
      pos_q     <= '0;
      removed_q <= '0;
      stat_q    <= ST_OK;
    end
    if (cmd_i.set_status) begin
      stat_q <= cmd_i.status;
    end
    if (cmd_i.found) begin
      pos_q <= pidx_q;
    end
    if (cmd_i.take_front) begin
      removed_q <= ram_rdata;
    end
    if (cmd_i.emit) begin
      status_o        <= stat_q;
      removed_value_o <= removed_q;
      position_o      <= pos_wide[POS_W-1:0];
      entry_count_o   <= cnt_wide[COUNT_W-1:0];
    end
  end

  `MTF_ASSERT(a_len_bound, len_q <= LEN_MAX, "list length above depth")
  `MTF_ASSERT(a_match_in_list, !(cmd_i.found && pidx_q >= len_q), "match beyond tail")
  `MTF_ASSERT_NEXT(a_insert_grows, cmd_i.push_front || cmd_i.push_back, len_q == $past(len_q) + 1'b1, "insert did not grow list")

endmodule

### hdl/mtf_ctrl.sv
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer: decodes each transaction and steps the datapath through
// insert, pop, scan and shift phases, then hands the result out.
// ----------------------------------------------------------------------------
module mtf_ctrl import mtf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FRONT,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        unique case (op_e'(sts_i.op))
          OP_INS_FRONT: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.push_front = 1'b1;
            end
          end
          OP_INS_BACK: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.push_back = 1'b1;
            end
          end
          OP_REM_FRONT: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
            end else begin
              cmd_o.read_front = 1'b1;
              state_d          = S_FRONT;
            end
          end
          OP_REM_VALUE, OP_SEARCH, OP_MOVE_FRONT: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NOTFOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_FRONT: begin
        cmd_o.take_front = 1'b1;
        state_d          = S_FINISH;
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          cmd_o.found = 1'b1;
          if (op_e'(sts_i.op) == OP_SEARCH) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.shift_start = 1'b1;
            state_d           = S_SHIFT;
          end
        end else if (sts_i.miss) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOTFOUND;
          state_d          = S_FINISH;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          if (op_e'(sts_i.op) == OP_MOVE_FRONT) begin
            cmd_o.tail_front = 1'b1;
          end else begin
            cmd_o.tail_remove = 1'b1;
          end
          state_d = S_FINISH;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/move_to_front_list_engine.sv
// ----------------------------------------------------------------------------
// move_to_front_list_engine: self-organizing list, one status per transaction
// Flow: one transaction in flight; the next is accepted the cycle after the
//   result is loaded into the output register.
// Reset: asynchronous, empties the list; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module move_to_front_list_engine import mtf_pkg::*; #(
  parameter int unsigned DEPTH = MTF_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic signed [VAL_W-1:0] value_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic signed [VAL_W-1:0] removed_value_o,
  output logic [POS_W-1:0]        position_o,
  output logic [COUNT_W-1:0]      entry_count_o
);

  // The list is a circular buffer in RAM: head points at entry 0, so
  // insert front, insert back and remove front are a single RAM access.
  // Remove value and move to front scan from the head for the first match,
  // then shift the entries ahead of it back by one slot, walking toward
  // the head. Removal then drops the head slot; move to front overwrites
  // it with the matched value. Failed operations never touch the list.
  //
  // The result sits in an output register, so a new transaction is taken
  // while the previous result still waits on out_stall_i.

  cmd_t cmd;
  sts_t sts;

  mtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtf_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .position_o     (position_o),
    .entry_count_o  (entry_count_o)
  );

endmodule
